// ===== rtl/core/cpp_pkg.sv =====
// Shared types and constants for the conditional prefix prepender.
// Used by cpp_regs, cpp_ctrl, cpp_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int TEXT_BYTES = 8;
    localparam int TEXT_W     = 64;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_TEXT   = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_SKIP   = 2'd2;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_EOS  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        DEC_UNDECIDED = 2'd0,
        DEC_PREPEND   = 2'd1,
        DEC_SKIP      = 2'd2
    } decision_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STR,
        ST_HELD,
        ST_BYTE
    } state_t;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_STR,
        SRC_HELD,
        SRC_BYTE
    } src_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic out_load;
        src_t out_src;
        logic out_last;
        logic idx_clr;
        logic idx_inc;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic plan_str;
        logic plan_held;
        logic plan_byte;
        logic str_end;
        logic held_end;
    } stat_t;

    function automatic logic [7:0] text_byte(input logic [TEXT_W-1:0] text,
                                             input logic [2:0] k);
        text_byte = text[{k, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/core/cpp_regs.sv =====
// APB configuration registers: prefix text, prefix length, skip-on-match.
// Depends on cpp_pkg.
`timescale 1ns / 1ps

module cpp_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cpp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cpp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cpp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [cpp_pkg::TEXT_W-1:0]       prefix_text,
    output logic [3:0]                       prefix_length,
    output logic                             skip_on_match
);

    logic [cpp_pkg::TEXT_W-1:0] text_reg;
    logic [3:0]                 length_reg;
    logic                       skip_reg;
    logic [1:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_reg   <= '0;
            length_reg <= '0;
            skip_reg   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                cpp_pkg::REG_TEXT:   text_reg   <= pwdata;
                cpp_pkg::REG_LENGTH: length_reg <= pwdata[3:0];
                cpp_pkg::REG_SKIP:   skip_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cpp_pkg::REG_TEXT:   prdata = text_reg;
            cpp_pkg::REG_LENGTH: prdata = {{(cpp_pkg::APB_DATA_W-4){1'b0}}, length_reg};
            cpp_pkg::REG_SKIP:   prdata = {{(cpp_pkg::APB_DATA_W-1){1'b0}}, skip_reg};
            default:             prdata = '0;
        endcase
    end

    assign prefix_text   = text_reg;
    assign prefix_length = length_reg;
    assign skip_on_match = skip_reg;

endmodule

// ===== rtl/core/cpp_ctrl.sv =====
// Controller: input handshake, output valid, and sequencing of the
// string / held / byte phases. Depends on cpp_pkg.
`timescale 1ns / 1ps

module cpp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  cpp_pkg::stat_t stat,
    output cpp_pkg::cmd_t  cmd
);

    cpp_pkg::state_t state_reg, state_next;
    logic plan_held_reg, plan_held_next;
    logic plan_byte_reg, plan_byte_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == cpp_pkg::ST_IDLE) && slot_free;
    assign m_tvalid  = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cpp_pkg::ST_IDLE;
            plan_held_reg <= 1'b0;
            plan_byte_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            plan_held_reg <= plan_held_next;
            plan_byte_reg <= plan_byte_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        plan_held_next = plan_held_reg;
        plan_byte_next = plan_byte_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        cmd            = '0;
        cmd.out_src    = cpp_pkg::SRC_IN;
        cmd.accept     = s_tvalid && s_tready;

        unique case (state_reg)
            cpp_pkg::ST_IDLE: begin
                if (cmd.accept) begin
                    plan_held_next = stat.plan_held;
                    plan_byte_next = stat.plan_byte;
                    priority if (stat.plan_str) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = cpp_pkg::ST_STR;
                    end else if (stat.plan_held) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = cpp_pkg::ST_HELD;
                    end else if (stat.plan_byte) begin
                        // plain pass-through: straight into the output register
                        cmd.out_load  = 1'b1;
                        cmd.out_src   = cpp_pkg::SRC_IN;
                        cmd.out_last  = 1'b1;
                        m_tvalid_next = 1'b1;
                    end else begin
                        // word only held for matching, or an end of stream with nothing to flush: nothing to emit
                        state_next = cpp_pkg::ST_IDLE;
                    end
                end
            end
            cpp_pkg::ST_STR: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_src   = cpp_pkg::SRC_STR;
                    m_tvalid_next = 1'b1;
                    if (stat.str_end) begin
                        cmd.out_last = !plan_held_reg && !plan_byte_reg;
                        cmd.idx_clr  = 1'b1;
                        priority if (plan_held_reg) state_next = cpp_pkg::ST_HELD;
                        else if (plan_byte_reg)     state_next = cpp_pkg::ST_BYTE;
                        else                        state_next = cpp_pkg::ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            cpp_pkg::ST_HELD: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_src   = cpp_pkg::SRC_HELD;
                    m_tvalid_next = 1'b1;
                    if (stat.held_end) begin
                        cmd.out_last = !plan_byte_reg;
                        state_next   = plan_byte_reg ? cpp_pkg::ST_BYTE : cpp_pkg::ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            cpp_pkg::ST_BYTE: begin
                if (slot_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_src   = cpp_pkg::SRC_BYTE;
                    cmd.out_last  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = cpp_pkg::ST_IDLE;
                end
            end
            default: state_next = cpp_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/cpp_dp.sv =====
// Datapath: decision and match state, held-byte store, phase index and
// output register. Depends on cpp_pkg.
`timescale 1ns / 1ps

module cpp_dp #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cpp_pkg::cmd_t                 cmd,
    output cpp_pkg::stat_t                stat,
    input  logic [cpp_pkg::TEXT_W-1:0]    prefix_text,
    input  logic [3:0]                    prefix_length,
    input  logic                          skip_on_match,
    input  logic                          in_opcode,
    input  logic [7:0]                    in_byte,
    input  logic                          in_first,
    output logic [7:0]                    out_byte,
    output logic                          out_from_prefix,
    output logic                          out_last
);

    localparam int IDXW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW   = $clog2(HOLD_DEPTH + 1);

    cpp_pkg::decision_t decision_reg, dec_next;
    logic [CW-1:0]   held_cnt_reg, cnt_next;
    logic [CW-1:0]   held_n_reg, held_n_next;
    logic [7:0]      held_mem [HOLD_DEPTH];
    logic [7:0]      byte_reg;
    logic [IDXW-1:0] idx_reg;
    logic [7:0]      out_byte_reg;
    logic            out_pre_reg;
    logic            out_last_reg;

    logic [CW-1:0]   len;
    logic [CW-1:0]   cnt_inc;
    logic [IDXW-1:0] pos;
    logic [7:0]      text_at_pos;
    logic            do_str, do_byte, wr_en, undecided;

    // Effective string length, clamped to the hold depth
    assign len = (prefix_length > 4'(HOLD_DEPTH)) ? CW'(HOLD_DEPTH) : prefix_length[CW-1:0];

    assign cnt_inc     = held_cnt_reg + CW'(1);
    assign pos         = held_cnt_reg[IDXW-1:0];
    assign text_at_pos = cpp_pkg::text_byte(prefix_text, 3'(pos));
    assign undecided   = (decision_reg == cpp_pkg::DEC_UNDECIDED);

    always_comb begin
        dec_next    = decision_reg;
        cnt_next    = held_cnt_reg;
        held_n_next = '0;
        do_str      = 1'b0;
        do_byte     = 1'b0;
        wr_en       = 1'b0;
        priority if (in_opcode == cpp_pkg::OP_EOS) begin
            do_str      = undecided && (held_cnt_reg != '0);
            held_n_next = undecided ? held_cnt_reg : '0;
            dec_next    = cpp_pkg::DEC_UNDECIDED;
            cnt_next    = '0;
        end else if (!undecided) begin
            do_byte = 1'b1;
        end else if (skip_on_match && in_first) begin
            dec_next    = cpp_pkg::DEC_SKIP;
            held_n_next = held_cnt_reg;
            cnt_next    = '0;
            do_byte     = 1'b1;
        end else if (!skip_on_match) begin
            dec_next    = cpp_pkg::DEC_PREPEND;
            held_n_next = held_cnt_reg;
            cnt_next    = '0;
            do_str      = 1'b1;
            do_byte     = 1'b1;
        end else if (held_cnt_reg >= len) begin
            dec_next    = cpp_pkg::DEC_SKIP;
            held_n_next = held_cnt_reg;
            cnt_next    = '0;
            do_byte     = 1'b1;
        end else begin
            wr_en = 1'b1;
            priority if (in_byte != text_at_pos) begin
                dec_next    = cpp_pkg::DEC_PREPEND;
                held_n_next = cnt_inc;
                cnt_next    = '0;
                do_str      = 1'b1;
            end else if (cnt_inc >= len) begin
                dec_next    = cpp_pkg::DEC_SKIP;
                held_n_next = cnt_inc;
                cnt_next    = '0;
            end else begin
                cnt_next = cnt_inc;
            end
        end
    end

    assign stat.plan_str  = do_str && (len != '0);
    assign stat.plan_held = (held_n_next != '0);
    assign stat.plan_byte = do_byte;
    assign stat.str_end   = (CW'(idx_reg) + CW'(1)) == len;
    assign stat.held_end  = (CW'(idx_reg) + CW'(1)) == held_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decision_reg <= cpp_pkg::DEC_UNDECIDED;
            held_cnt_reg <= '0;
            held_n_reg   <= '0;
            idx_reg      <= '0;
        end else begin
            if (cmd.accept) begin
                decision_reg <= dec_next;
                held_cnt_reg <= cnt_next;
                held_n_reg   <= held_n_next;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDXW'(1);
            end
        end
    end

    // Held-byte store and payload registers: no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= in_byte;
        end
        if (cmd.accept && wr_en) begin
            held_mem[pos] <= in_byte;
        end
        if (cmd.out_load) begin
            out_last_reg <= cmd.out_last;
            unique case (cmd.out_src)
                cpp_pkg::SRC_IN: begin
                    out_byte_reg <= in_byte;
                    out_pre_reg  <= 1'b0;
                end
                cpp_pkg::SRC_STR: begin
                    out_byte_reg <= cpp_pkg::text_byte(prefix_text, 3'(idx_reg));
                    out_pre_reg  <= 1'b1;
                end
                cpp_pkg::SRC_HELD: begin
                    out_byte_reg <= held_mem[idx_reg];
                    out_pre_reg  <= 1'b0;
                end
                cpp_pkg::SRC_BYTE: begin
                    out_byte_reg <= byte_reg;
                    out_pre_reg  <= 1'b0;
                end
                default: begin
                    out_byte_reg <= byte_reg;
                    out_pre_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign out_byte        = out_byte_reg;
    assign out_from_prefix = out_pre_reg;
    assign out_last        = out_last_reg;

endmodule

// ===== rtl/core/conditional_prefix_prepender.sv =====
// Top level of the conditional prefix prepender: registers, controller, datapath.
// Depends on cpp_pkg, cpp_regs, cpp_ctrl and cpp_dp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tdata: data_byte; tuser: opcode, start_taken
//  m_      | out       | m_tvalid/m_tready  | tdata: out_byte; tuser: from_prefix; tlast
//  apb     | in        | psel/penable/pready| text @0x00, length @0x08, skip @0x10
//
// A word that only passes through, or is only held for matching, leaves the sequencer idle,
// so a decided stream runs at one word per cycle while m_tready does not stall. A word that
// releases a burst blocks the input until its results are out (string bytes, then held
// bytes, then the word's own byte if it passes): the single output register drains the burst
// one word per cycle while m_tready does not stall.
// Reset (aresetn low at a clock edge) clears the registers, the decision and the
// held count. A stall on m_tready holds the output word and stops the sequencer.
`timescale 1ns / 1ps

module conditional_prefix_prepender #(
    parameter int MAX_PREPEND = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [1:0]                       s_tuser,   // [0] opcode, [1] start_taken
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic [0:0]                       m_tuser,   // [0] from_prefix
    output logic                             m_tlast,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cpp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cpp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cpp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // Hold depth is bounded by the eight bytes of the text register
    localparam int HOLD_DEPTH = (MAX_PREPEND < cpp_pkg::TEXT_BYTES) ?
                                MAX_PREPEND : cpp_pkg::TEXT_BYTES;

    cpp_pkg::cmd_t  cmd;
    cpp_pkg::stat_t stat;
    logic [cpp_pkg::TEXT_W-1:0] prefix_text;
    logic [3:0]                 prefix_length;
    logic                       skip_on_match;

    cpp_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .prefix_text   (prefix_text),
        .prefix_length (prefix_length),
        .skip_on_match (skip_on_match)
    );

    // Sequencer: accepts a word, then walks the string, held and byte phases
    cpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Match state, held bytes and the output register
    cpp_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .prefix_text     (prefix_text),
        .prefix_length   (prefix_length),
        .skip_on_match   (skip_on_match),
        .in_opcode       (s_tuser[0]),
        .in_byte         (s_tdata),
        .in_first        (s_tuser[1]),
        .out_byte        (m_tdata),
        .out_from_prefix (m_tuser[0]),
        .out_last        (m_tlast)
    );

    // Never overwrite a word that is still waiting at the output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output word overwritten while stalled");

    // A burst blocks the input for at least the following cycle
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (stat.plan_str || stat.plan_held)) |=> !s_tready)
        else $error("input accepted during a burst");

    // The direct input path is used only in the cycle a word is accepted
    a_direct_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_src == cpp_pkg::SRC_IN) |-> cmd.accept)
        else $error("direct output load without an accepted word");

endmodule

// ===== test/tb_conditional_prefix_prepender.sv =====
// Self-checking testbench for conditional_prefix_prepender: directed table, then random streams.
// Predicts words by a behavioral copy or typed-in rows; depends on cpp_pkg and the top level.
`timescale 1ns / 1ps

module tb_conditional_prefix_prepender;

    localparam int MAX_PREPEND = 8;
    localparam int HOLD_DEPTH  = (MAX_PREPEND < cpp_pkg::TEXT_BYTES) ?
                                 MAX_PREPEND : cpp_pkg::TEXT_BYTES;
    // let a word that causes no output finish before touching the registers
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 3000;
    // short names for the package codes used in the table
    localparam logic [1:0] REG_TEXT   = cpp_pkg::REG_TEXT;
    localparam logic [1:0] REG_LENGTH = cpp_pkg::REG_LENGTH;
    localparam logic [1:0] REG_SKIP   = cpp_pkg::REG_SKIP;
    localparam cpp_pkg::opcode_t OP_DATA = cpp_pkg::OP_DATA;
    localparam cpp_pkg::opcode_t OP_EOS  = cpp_pkg::OP_EOS;
    // register index with no register behind it
    localparam logic [1:0] REG_NONE = 2'd3;

    // how a table row is checked
    typedef enum logic [1:0] {
        EXP_MODEL,   // from the predictor
        EXP_NONE,    // no output word
        EXP_ONE      // exactly the typed-in word, marked last
    } exp_kind_t;

    typedef struct packed {
        logic       is_cfg;
        logic [1:0] reg_idx;
        logic [63:0] value;
        cpp_pkg::opcode_t op;
        logic [7:0] data;
        logic       fc;
        exp_kind_t  kind;
        logic [7:0] t_byte;
        logic       t_pre;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       from_prefix;
        logic       last;
    } out_word_t;

    localparam logic [63:0] TAG3 = 64'h0000_0000_003E_733C;   // "<s>"
    localparam logic [63:0] ONES = {64{1'b1}};

    // Directed part: reset state, extremes, every branch of the decision logic,
    // and the register changes that land while bytes are held.
    localparam int PLAN_LEN = 39;
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        // empty string, always-prepend mode right after reset: byte passes alone
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h41, 1'b0, EXP_ONE,   8'h41, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'hFF, 1'b1, EXP_ONE,   8'hFF, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        '{1'b1, REG_TEXT,   TAG3,  OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b1, REG_LENGTH, 64'd3, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        // always-prepend: the start-taken flag has no effect
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h00, 1'b1, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h7F, 1'b0, EXP_ONE,   8'h7F, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'hFF, 1'b1, EXP_NONE,  8'h00, 1'b0},
        '{1'b1, REG_SKIP,   64'd1, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        // full match: held bytes only
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h3C, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h73, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h3E, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h80, 1'b0, EXP_ONE,   8'h80, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        // mismatch on the second byte: string, then held bytes
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h3C, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        // end of stream after a partial match
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h3C, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h3C, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        // start taken while holding
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h3C, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h55, 1'b1, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        // write to an unused index, text of all ones, then length above the hold depth
        '{1'b1, REG_NONE,   ONES,  OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b1, REG_TEXT,   ONES,  OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b1, REG_LENGTH, 64'd15, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'hFF, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'hFF, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        // length lowered under the held count: next byte decides skip and passes
        '{1'b1, REG_LENGTH, 64'd1, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h12, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        // mode switched to always-prepend while a byte is held
        '{1'b1, REG_LENGTH, 64'd8, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'hFF, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b1, REG_SKIP,   64'd0, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h34, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0},
        // empty string in conditional mode: byte decides skip and passes
        '{1'b1, REG_LENGTH, 64'd0, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b1, REG_SKIP,   64'd1, OP_DATA, 8'h00, 1'b0, EXP_MODEL, 8'h00, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_DATA, 8'h01, 1'b0, EXP_ONE,   8'h01, 1'b0},
        '{1'b0, REG_TEXT,   64'd0, OP_EOS,  8'h00, 1'b0, EXP_NONE,  8'h00, 1'b0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic [1:0]  s_tuser  = 2'b00;   // [0] opcode, [1] start_taken
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic [0:0]  m_tuser;            // [0] from_prefix
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [cpp_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [cpp_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [cpp_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    conditional_prefix_prepender #(.MAX_PREPEND(MAX_PREPEND)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Behavioral copy of the block: registers, decision and held bytes.
    logic [63:0] cfg_text   = '0;
    logic [3:0]  cfg_length = '0;
    logic        cfg_skip   = 1'b0;
    cpp_pkg::decision_t decision = cpp_pkg::DEC_UNDECIDED;
    int          held_count = 0;
    logic [7:0]  held_bytes [cpp_pkg::TEXT_BYTES];

    out_word_t   item_words [$];      // words caused by the current input word
    out_word_t   expected_words [$];  // words still owed by the block
    out_word_t   oldest;

    int errors       = 0;
    int idle_cycles  = 0;
    int src_idle_pct = 11;
    int dst_idle_pct = 62;

    function automatic int prefix_len();
        int len;
        len = cfg_length;
        if (len > HOLD_DEPTH)
            len = HOLD_DEPTH;
        return len;
    endfunction

    function automatic logic [7:0] prefix_byte(input int k);
        return cfg_text[(k % cpp_pkg::TEXT_BYTES) * 8 +: 8];
    endfunction

    function automatic void emit_prefix();
        for (int k = 0; k < prefix_len(); k++)
            item_words.push_back('{prefix_byte(k), 1'b1, 1'b0});
    endfunction

    function automatic void emit_held();
        for (int k = 0; k < held_count; k++)
            item_words.push_back('{held_bytes[k], 1'b0, 1'b0});
        held_count = 0;
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [63:0] value);
        case (idx)
            REG_TEXT:   cfg_text = value;
            REG_LENGTH: cfg_length = value[3:0];
            REG_SKIP:   cfg_skip = value[0];
            default: ;
        endcase
    endfunction

    // Work out the words one accepted input word causes and advance the state.
    function automatic void compute_prefix_output(input cpp_pkg::opcode_t op,
                                                  input logic [7:0] b, input logic fc);
        int len;
        int pos;
        len = prefix_len();
        item_words.delete();
        if (op == OP_EOS) begin
            if (decision == cpp_pkg::DEC_UNDECIDED && held_count > 0) begin
                emit_prefix();
                emit_held();
            end
            decision = cpp_pkg::DEC_UNDECIDED;
            held_count = 0;
        end else if (decision != cpp_pkg::DEC_UNDECIDED) begin
            item_words.push_back('{b, 1'b0, 1'b0});
        end else if (cfg_skip && fc) begin
            decision = cpp_pkg::DEC_SKIP;
            emit_held();
            item_words.push_back('{b, 1'b0, 1'b0});
        end else if (!cfg_skip) begin
            decision = cpp_pkg::DEC_PREPEND;
            emit_prefix();
            emit_held();
            item_words.push_back('{b, 1'b0, 1'b0});
        end else if (held_count >= len) begin
            decision = cpp_pkg::DEC_SKIP;
            emit_held();
            item_words.push_back('{b, 1'b0, 1'b0});
        end else begin
            pos = held_count;
            held_bytes[pos] = b;
            held_count = pos + 1;
            if (b != prefix_byte(pos)) begin
                decision = cpp_pkg::DEC_PREPEND;
                emit_prefix();
                emit_held();
            end else if (held_count >= len) begin
                decision = cpp_pkg::DEC_SKIP;
                emit_held();
            end
        end
        if (item_words.size() > 0)
            item_words[item_words.size() - 1].last = 1'b1;
    endfunction

    // Offer one input word after a random gap; record what it owes once accepted.
    task automatic send_word(input cpp_pkg::opcode_t op, input logic [7:0] b, input logic fc,
                             input exp_kind_t kind, input logic [7:0] t_byte,
                             input logic t_pre);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {fc, op};
        do @(posedge aclk); while (!s_tready);
        compute_prefix_output(op, b, fc);
        case (kind)
            EXP_MODEL: foreach (item_words[i]) expected_words.push_back(item_words[i]);
            EXP_ONE:   expected_words.push_back('{t_byte, t_pre, 1'b1});
            default: ;
        endcase
    endtask

    // Drop valid and hold until every owed word is out, then let the block settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the pready edge.
    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Random streams: mostly a leading run of string bytes (full or cut short, then a
    // mismatch or an end), a body and an end of stream; the rest is loose noise.
    task automatic run_streams(input int budget);
        int sent;
        int n;
        int k;
        int len;
        logic [7:0] b;
        sent = 0;
        while (sent < budget) begin
            len = prefix_len();
            if ($urandom_range(99) < 70) begin
                n = ($urandom_range(1) == 1) ? len : $urandom_range(len);
                for (k = 0; k < n; k++) begin
                    send_word(OP_DATA, prefix_byte(k), ($urandom_range(99) < 8),
                              EXP_MODEL, 8'h00, 1'b0);
                    sent++;
                end
                if (n < len && $urandom_range(1) == 1) begin
                    b = prefix_byte(n) ^ 8'($urandom_range(1, 255));
                    send_word(OP_DATA, b, ($urandom_range(99) < 8), EXP_MODEL, 8'h00, 1'b0);
                    sent++;
                end
                n = $urandom_range(5);
                for (k = 0; k < n; k++) begin
                    send_word(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              EXP_MODEL, 8'h00, 1'b0);
                    sent++;
                end
                if ($urandom_range(99) < 90) begin
                    send_word(OP_EOS, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              EXP_MODEL, 8'h00, 1'b0);
                    sent++;
                end
            end else begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    send_word(cpp_pkg::opcode_t'($urandom_range(99) < 25),
                              8'($urandom_range(255)), 1'($urandom_range(1)),
                              EXP_MODEL, 8'h00, 1'b0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: stall at the rate of the current phase.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    // Compare every accepted output word with the oldest owed word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte %02h from_prefix %0d last %0d",
                       m_tdata, m_tuser[0], m_tlast);
                errors++;
            end else begin
                oldest = expected_words.pop_front();
                if (m_tdata !== oldest.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", oldest.out_byte, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== oldest.from_prefix) begin
                    $error("from_prefix: expected %0d, got %0d", oldest.from_prefix,
                           m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== oldest.last) begin
                    $error("last: expected %0d, got %0d", oldest.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves a word for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** conditional_prefix_prepender: FAILED **");
            $finish;
        end
    end

    initial begin
        int p;
        logic [63:0] text;
        logic [3:0]  len;
        logic        skip;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, sender eager and receiver busy
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].is_cfg) begin
                wait_drained();
                write_register(PLAN[r].reg_idx, PLAN[r].value);
            end else begin
                send_word(PLAN[r].op, PLAN[r].data, PLAN[r].fc, PLAN[r].kind,
                          PLAN[r].t_byte, PLAN[r].t_pre);
            end
        end

        // three idling modes, three register settings in each
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 62 : 0;
            dst_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 11 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                p = mode * 3 + sub;
                text = {$urandom, $urandom};
                if (p == 3)
                    text = ONES;
                else if (p == 6)
                    text = '0;
                if (sub == 0)
                    len = 4'd8;
                else if (p == 1)
                    len = 4'd15;
                else if (sub == 1)
                    len = 4'($urandom_range(15));
                else
                    len = 4'($urandom_range(3));
                skip = (p == 2) ? 1'b0 : ($urandom_range(99) < 75);
                wait_drained();
                write_register(REG_TEXT, text);
                write_register(REG_LENGTH, {60'd0, len});
                write_register(REG_SKIP, {63'd0, skip});
                run_streams(25);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("** conditional_prefix_prepender: PASSED **");
        else
            $display("** conditional_prefix_prepender: FAILED **");
        $finish;
    end

endmodule
